// File: rtl/cvc_pkg.sv
// cvc_pkg: shared types and constants of the Cartesian velocity command unit
// no dependencies; used by the top level, its checker and the testbench
package cvc_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_PROD,
    ST_DIV,
    ST_SM1,
    ST_SM2,
    ST_FIN
  } state_e;

  // operation codes of an input item
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_GOAL = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_DEADBAND = 2'd0;
  localparam logic [1:0] CFG_DECAY    = 2'd1;
  localparam logic [1:0] CFG_ALPHA    = 2'd2;

  // configuration reset values
  localparam logic [24:0] DEADBAND_RST = 25'd335544;
  localparam logic [15:0] DECAY_RST    = 16'd58982;
  localparam logic [15:0] ALPHA_RST    = 16'd655;

  // serial unit step counts
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MUL_STEPS  = 32 / DIGIT_W;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 34;

  localparam logic [1:0] LAST_AXIS = 2'd2;

endpackage

// File: rtl/cartesian_velocity_command_unit.sv
// Cartesian velocity command unit: velocity toward a stored target, decayed inside the deadband, low-pass filtered
// depends on cvc_pkg; one shared 4-bit-digit multiplier, bit-serial square root and divider
// Sequence of a tick: three squares, a 32-step root, per axis a product and, outside the
// deadband, a 34-step divide, then six smoothing products and the registered result
// One item at a time: the input stalls while a tick is in work; a target item gives no result
// Reset: asynchronous active low; clears target, speed and filter velocity (not vel_*_o), loads default config
module cartesian_velocity_command_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] goal_x_i,
  input  logic [31:0] goal_y_i,
  input  logic [31:0] goal_z_i,
  input  logic [31:0] goal_speed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] vel_x_o,
  output logic [31:0] vel_y_o,
  output logic [31:0] vel_z_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [24:0] cfg_data_i
);

  cvc_pkg::state_e state_q, state_d;

  logic [24:0] deadband_q;
  logic [15:0] decay_fac_q;
  logic [15:0] alpha_q;

  logic [31:0] goal_q [3];
  logic [31:0] speed_q;
  logic        known_q;
  logic [31:0] prev_q [3];
  logic [31:0] raw_q  [3];
  logic [32:0] d_q    [3];

  logic [63:0] mc_q, acc_q, rad_q;
  logic [31:0] mp_q, root_q;
  logic [33:0] srem_q, dvd_q, quo_q;
  logic [32:0] drem_q;
  logic [48:0] s1_q;
  logic [5:0]  cnt_q;
  logic [1:0]  axis_q;
  logic        hold_q;
  logic        out_valid_q;
  logic [31:0] vel_q [3];

  logic [31:0] pos_a [3];
  logic [32:0] d_new [3];
  logic        tick_acc, goal_acc, last_axis;
  logic        mul_end, root_end, div_end, out_free;

  // input handshake
  assign pos_a[0] = pos_x_i;
  assign pos_a[1] = pos_y_i;
  assign pos_a[2] = pos_z_i;
  assign tick_acc = in_valid_i && !in_stall_o && (operation_i == cvc_pkg::OP_TICK);
  assign goal_acc = in_valid_i && !in_stall_o && (operation_i == cvc_pkg::OP_GOAL);
  assign last_axis = (axis_q == cvc_pkg::LAST_AXIS);
  assign mul_end  = (cnt_q == 6'(cvc_pkg::MUL_STEPS - 1));
  assign root_end = (cnt_q == 6'(cvc_pkg::ROOT_STEPS - 1));
  assign div_end  = (cnt_q == 6'(cvc_pkg::DIV_STEPS - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  // difference vector, with the tick position as target until one is known
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_new[k] = known_q ? 33'($signed(goal_q[k])) - 33'($signed(pos_a[k])) : 33'd0;
    end
  end

  // magnitudes at the fixed head places of the rotating lanes
  logic [32:0] dmag0, dmag1, dnmag0;
  logic [31:0] pmag0, pmag1, rmag0, smag;
  assign dmag0  = d_q[0][32] ? 33'(-d_q[0]) : d_q[0];
  assign dmag1  = d_q[1][32] ? 33'(-d_q[1]) : d_q[1];
  assign dnmag0 = d_new[0][32] ? 33'(-d_new[0]) : d_new[0];
  assign pmag0  = prev_q[0][31] ? 32'(-prev_q[0]) : prev_q[0];
  assign pmag1  = prev_q[1][31] ? 32'(-prev_q[1]) : prev_q[1];
  assign rmag0  = raw_q[0][31] ? 32'(-raw_q[0]) : raw_q[0];
  assign smag   = speed_q[31] ? 32'(-speed_q) : speed_q;

  // digit multiplier step
  logic [67:0] pp;
  logic [63:0] acc_nx;
  assign pp     = mc_q * mp_q[cvc_pkg::DIGIT_W-1:0];
  assign acc_nx = acc_q + pp[63:0];

  // square root step
  logic [35:0] srem_t, strial;
  logic        sge;
  logic [31:0] root_nx;
  logic [33:0] srem_nx;
  logic        hold_nx;
  assign srem_t  = {srem_q, rad_q[63:62]};
  assign strial  = {2'b00, root_q, 2'b01};
  assign sge     = (srem_t >= strial);
  assign root_nx = {root_q[30:0], sge};
  assign srem_nx = sge ? 34'(srem_t - strial) : srem_t[33:0];
  assign hold_nx = (root_nx == 32'd0) || ({root_nx, 1'b0} < {8'd0, deadband_q});

  // divide step
  logic [32:0] norm;
  logic [33:0] drem_t;
  logic        dge;
  logic [32:0] drem_nx;
  logic [33:0] quo_nx;
  assign norm    = {root_q, 1'b0};
  assign drem_t  = {drem_q, dvd_q[33]};
  assign dge     = (drem_t >= {1'b0, norm});
  assign drem_nx = dge ? 33'(drem_t - {1'b0, norm}) : drem_t[32:0];
  assign quo_nx  = {quo_q[32:0], dge};

  // raw velocity of the current axis
  logic signed [48:0] dsp;
  logic        q_big, tneg;
  logic [31:0] raw_new;
  always_comb begin
    dsp = prev_q[0][31] ? -$signed({1'b0, acc_nx[47:0]}) : $signed({1'b0, acc_nx[47:0]});
    q_big = |quo_nx[33:31];
    tneg  = speed_q[31] ^ d_q[0][32];
    if (hold_q) begin
      raw_new = 32'(dsp >>> 16);
    end else if (tneg) begin
      raw_new = q_big ? 32'h8000_0000 : 32'(-quo_nx[31:0]);
    end else begin
      raw_new = q_big ? 32'h7FFF_FFFF : quo_nx[31:0];
    end
  end

  // smoothing sum, floor and saturation
  logic signed [48:0] s2;
  logic signed [49:0] smsum, smsh;
  logic [31:0] prev_new;
  always_comb begin
    s2 = raw_q[0][31] ? -$signed({1'b0, acc_nx[47:0]}) : $signed({1'b0, acc_nx[47:0]});
    smsum = 50'($signed(s1_q)) + 50'(s2);
    smsh  = smsum >>> 16;
    if (!smsh[49] && (|smsh[48:31])) begin
      prev_new = 32'h7FFF_FFFF;
    end else if (smsh[49] && !(&smsh[48:31])) begin
      prev_new = 32'h8000_0000;
    end else begin
      prev_new = smsh[31:0];
    end
  end

  // lane rotation points
  logic rot_lane;
  assign rot_lane = ((state_q == cvc_pkg::ST_PROD) && mul_end && hold_q)
                 || ((state_q == cvc_pkg::ST_DIV) && div_end);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cvc_pkg::ST_IDLE: if (tick_acc) state_d = cvc_pkg::ST_SQ;
      cvc_pkg::ST_SQ:   if (mul_end && last_axis) state_d = cvc_pkg::ST_ROOT;
      cvc_pkg::ST_ROOT: if (root_end) state_d = cvc_pkg::ST_PROD;
      cvc_pkg::ST_PROD: begin
        if (mul_end) begin
          if (!hold_q) state_d = cvc_pkg::ST_DIV;
          else if (last_axis) state_d = cvc_pkg::ST_SM1;
        end
      end
      cvc_pkg::ST_DIV: begin
        if (div_end) state_d = last_axis ? cvc_pkg::ST_SM1 : cvc_pkg::ST_PROD;
      end
      cvc_pkg::ST_SM1:  if (mul_end) state_d = cvc_pkg::ST_SM2;
      cvc_pkg::ST_SM2: begin
        if (mul_end) state_d = last_axis ? cvc_pkg::ST_FIN : cvc_pkg::ST_SM1;
      end
      cvc_pkg::ST_FIN:  if (out_free) state_d = cvc_pkg::ST_IDLE;
      default:          state_d = cvc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = (state_q != cvc_pkg::ST_IDLE);
    out_valid_o = out_valid_q;
    vel_x_o     = vel_q[0];
    vel_y_o     = vel_q[1];
    vel_z_o     = vel_q[2];
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cvc_pkg::ST_IDLE;
      deadband_q  <= cvc_pkg::DEADBAND_RST;
      decay_fac_q <= cvc_pkg::DECAY_RST;
      alpha_q     <= cvc_pkg::ALPHA_RST;
      known_q     <= 1'b0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      axis_q      <= '0;
      hold_q      <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        goal_q[k] <= '0;
        prev_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= ((state_q == cvc_pkg::ST_FIN) && out_free) || (out_valid_q && out_stall_i);

      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cvc_pkg::CFG_DEADBAND: deadband_q  <= cfg_data_i;
          cvc_pkg::CFG_DECAY:    decay_fac_q <= cfg_data_i[15:0];
          cvc_pkg::CFG_ALPHA:    alpha_q     <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // target transfer, or first tick taken as target
      if (goal_acc) begin
        goal_q[0] <= goal_x_i;
        goal_q[1] <= goal_y_i;
        goal_q[2] <= goal_z_i;
        speed_q   <= goal_speed_i;
        known_q   <= 1'b1;
      end else if (tick_acc && !known_q) begin
        for (int k = 0; k < 3; k++) goal_q[k] <= pos_a[k];
        known_q <= 1'b1;
      end

      // step counter
      if (state_q == cvc_pkg::ST_IDLE || state_q == cvc_pkg::ST_FIN) begin
        cnt_q <= '0;
      end else if (((state_q == cvc_pkg::ST_SQ || state_q == cvc_pkg::ST_PROD
                   || state_q == cvc_pkg::ST_SM1 || state_q == cvc_pkg::ST_SM2) && mul_end)
                   || (state_q == cvc_pkg::ST_ROOT && root_end)
                   || (state_q == cvc_pkg::ST_DIV && div_end)) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 6'd1;
      end

      // axis counter
      if (tick_acc) begin
        axis_q <= '0;
      end else if ((state_q == cvc_pkg::ST_SQ && mul_end) || rot_lane
                   || (state_q == cvc_pkg::ST_SM2 && mul_end)) begin
        axis_q <= last_axis ? 2'd0 : 2'(axis_q + 2'd1);
      end

      if (state_q == cvc_pkg::ST_ROOT && root_end) hold_q <= hold_nx;

      // previous velocity lanes rotate with each finished axis
      if (rot_lane) begin
        prev_q[0] <= prev_q[1];
        prev_q[1] <= prev_q[2];
        prev_q[2] <= prev_q[0];
      end else if (state_q == cvc_pkg::ST_SM2 && mul_end) begin
        prev_q[0] <= prev_q[1];
        prev_q[1] <= prev_q[2];
        prev_q[2] <= prev_new;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      cvc_pkg::ST_IDLE: begin
        if (tick_acc) begin
          for (int k = 0; k < 3; k++) d_q[k] <= d_new[k];
          acc_q <= '0;
          mc_q  <= {32'd0, dnmag0[32:1]};
          mp_q  <= dnmag0[32:1];
        end
      end
      cvc_pkg::ST_SQ: begin
        acc_q <= acc_nx;
        if (mul_end) begin
          d_q[0] <= d_q[1];
          d_q[1] <= d_q[2];
          d_q[2] <= d_q[0];
          mc_q   <= {32'd0, dmag1[32:1]};
          mp_q   <= dmag1[32:1];
          rad_q  <= acc_nx;
          srem_q <= '0;
          root_q <= '0;
        end else begin
          mc_q <= mc_q << cvc_pkg::DIGIT_W;
          mp_q <= mp_q >> cvc_pkg::DIGIT_W;
        end
      end
      cvc_pkg::ST_ROOT: begin
        rad_q  <= rad_q << 2;
        srem_q <= srem_nx;
        root_q <= root_nx;
        if (root_end) begin
          acc_q <= '0;
          if (hold_nx) begin
            mc_q <= {32'd0, pmag0};
            mp_q <= {16'd0, decay_fac_q};
          end else begin
            mc_q <= {31'd0, dmag0};
            mp_q <= smag;
          end
        end
      end
      cvc_pkg::ST_PROD: begin
        if (!rot_lane) begin
          acc_q <= acc_nx;
          mc_q  <= mc_q << cvc_pkg::DIGIT_W;
          mp_q  <= mp_q >> cvc_pkg::DIGIT_W;
        end
        if (mul_end) begin
          drem_q <= {3'd0, acc_nx[63:34]};
          dvd_q  <= acc_nx[33:0];
          quo_q  <= '0;
        end
      end
      cvc_pkg::ST_DIV: begin
        drem_q <= drem_nx;
        dvd_q  <= dvd_q << 1;
        quo_q  <= quo_nx;
      end
      cvc_pkg::ST_SM1: begin
        if (mul_end) begin
          s1_q  <= dsp;
          acc_q <= '0;
          mc_q  <= {32'd0, rmag0};
          mp_q  <= {16'd0, alpha_q};
        end else begin
          acc_q <= acc_nx;
          mc_q  <= mc_q << cvc_pkg::DIGIT_W;
          mp_q  <= mp_q >> cvc_pkg::DIGIT_W;
        end
      end
      cvc_pkg::ST_SM2: begin
        if (mul_end) begin
          raw_q[0] <= raw_q[1];
          raw_q[1] <= raw_q[2];
          raw_q[2] <= raw_q[0];
          acc_q    <= '0;
          mc_q     <= {32'd0, pmag1};
          mp_q     <= 32'(17'h1_0000 - {1'b0, alpha_q});
        end else begin
          acc_q <= acc_nx;
          mc_q  <= mc_q << cvc_pkg::DIGIT_W;
          mp_q  <= mp_q >> cvc_pkg::DIGIT_W;
        end
      end
      cvc_pkg::ST_FIN: begin
        if (out_free) begin
          for (int k = 0; k < 3; k++) vel_q[k] <= prev_q[k];
        end
      end
      default: ;
    endcase

    // finished axis: store raw velocity, rotate lanes, load next product
    if (rot_lane) begin
      raw_q[0] <= raw_q[1];
      raw_q[1] <= raw_q[2];
      raw_q[2] <= raw_new;
      d_q[0]   <= d_q[1];
      d_q[1]   <= d_q[2];
      d_q[2]   <= d_q[0];
      acc_q    <= '0;
      if (last_axis) begin
        mc_q <= {32'd0, pmag1};
        mp_q <= 32'(17'h1_0000 - {1'b0, alpha_q});
      end else if (hold_q) begin
        mc_q <= {32'd0, pmag1};
        mp_q <= {16'd0, decay_fac_q};
      end else begin
        mc_q <= {31'd0, dmag1};
        mp_q <= smag;
      end
    end
  end

endmodule

// File: rtl/cvc_checker.sv
// cvc_checker: port-level assertions for the Cartesian velocity command unit
// depends on cvc_pkg; attached to the top level by the bind at the end of this file
module cvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        operation_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] vel_x_o,
  input logic [31:0] vel_y_o,
  input logic [31:0] vel_z_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(vel_x_o) && $stable(vel_y_o) && $stable(vel_z_o))
    else $error("result changed while stalled");

  // a tick transfer occupies the unit
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (operation_i == cvc_pkg::OP_TICK) |=> in_stall_o)
    else $error("unit free right after a tick");

  // a target transfer gives no result and leaves the unit free
  a_goal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (operation_i == cvc_pkg::OP_GOAL)
    |=> !in_stall_o && !$rose(out_valid_o))
    else $error("target transfer produced a result or stalled");

endmodule

bind cartesian_velocity_command_unit cvc_checker u_cvc_checker (.*);

// File: tb/tb.sv
// tb: self-checking testbench of cartesian_velocity_command_unit
// depends on cvc_pkg and the unit; an in-bench velocity predictor checks every result but typed-in rows
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vel_t;

  // one directed row: item fields and, where obvious, the typed-in velocity
  typedef struct {
    logic        op;
    logic [31:0] px, py, pz, gx, gy, gz, sp;
    bit          typed;
    vel_t        vel;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = cvc_pkg::OP_TICK;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [31:0] goal_x_i = '0, goal_y_i = '0, goal_z_i = '0, goal_speed_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] vel_x_o, vel_y_o, vel_z_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = cvc_pkg::CFG_DEADBAND;
  logic [24:0] cfg_data_i = '0;

  cartesian_velocity_command_unit uut (.*);

  // predictor copy of the unit state
  longint unsigned band_q, decay_q, alpha_q;
  longint aim_x, aim_y, aim_z, aim_speed;
  bit     target_set;
  longint last_vx, last_vy, last_vz;

  vel_t   pending_vel[$];
  int     errors = 0;
  int     n_ticks = 0, n_targets = 0, n_results = 0;
  bit     calm = 1'b0;
  int     stall_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat32(longint v);
    if (v > MAX32) return MAX32;
    if (v < MIN32) return MIN32;
    return v;
  endfunction

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // speed times unit vector component, magnitude clamped then saturated
  function automatic longint heading(longint d, longint unsigned norm);
    longint unsigned q;
    q = (magn(aim_speed) * magn(d)) / norm;
    if (q > 64'd2147483648) q = 64'd2147483648;
    return sat32(((aim_speed < 0) != (d < 0)) ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint lowpass(longint prev, longint raw);
    longint a;
    a = longint'(alpha_q);
    return sat32(((65536 - a) * prev + a * raw) >>> 16);
  endfunction

  // advance the predictor by one accepted item; returns 1 when a result follows
  function automatic bit velocity_step(logic op, logic [31:0] px, logic [31:0] py,
                                       logic [31:0] pz, logic [31:0] gx, logic [31:0] gy,
                                       logic [31:0] gz, logic [31:0] sp, output vel_t v);
    longint dx, dy, dz, rx, ry, rz;
    longint unsigned hx, hy, hz, h;
    v = '0;
    if (op == cvc_pkg::OP_GOAL) begin
      aim_x = longint'(signed'(gx));
      aim_y = longint'(signed'(gy));
      aim_z = longint'(signed'(gz));
      aim_speed = longint'(signed'(sp));
      target_set = 1'b1;
      return 1'b0;
    end
    if (!target_set) begin
      aim_x = longint'(signed'(px));
      aim_y = longint'(signed'(py));
      aim_z = longint'(signed'(pz));
      target_set = 1'b1;
    end
    dx = aim_x - longint'(signed'(px));
    dy = aim_y - longint'(signed'(py));
    dz = aim_z - longint'(signed'(pz));
    hx = magn(dx) >> 1;
    hy = magn(dy) >> 1;
    hz = magn(dz) >> 1;
    h = int_sqrt(hx * hx + hy * hy + hz * hz);
    if (h == 0 || 2 * h < band_q) begin
      rx = (last_vx * longint'(decay_q)) >>> 16;
      ry = (last_vy * longint'(decay_q)) >>> 16;
      rz = (last_vz * longint'(decay_q)) >>> 16;
    end else begin
      rx = heading(dx, 2 * h);
      ry = heading(dy, 2 * h);
      rz = heading(dz, 2 * h);
    end
    last_vx = lowpass(last_vx, rx);
    last_vy = lowpass(last_vy, ry);
    last_vz = lowpass(last_vz, rz);
    v.x = last_vx[31:0];
    v.y = last_vy[31:0];
    v.z = last_vz[31:0];
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // drive one item and wait for its transfer
  task automatic send_item(logic op, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                           logic [31:0] sp, bit typed, vel_t typed_vel);
    int   gap;
    vel_t v;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    goal_x_i <= gx; goal_y_i <= gy; goal_z_i <= gz; goal_speed_i <= sp;
    do @(posedge clk_i); while (in_stall_o);
    if (velocity_step(op, px, py, pz, gx, gy, gz, sp, v)) begin
      pending_vel.push_back(typed ? typed_vel : v);
      n_ticks++;
    end else begin
      n_targets++;
    end
  endtask

  // pause the sender until every result is back, then let the unit go idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_vel.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [24:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cvc_pkg::CFG_DEADBAND: band_q = 64'(data);
      cvc_pkg::CFG_DECAY:    decay_q = 64'(data[15:0]);
      cvc_pkg::CFG_ALPHA:    alpha_q = 64'(data[15:0]);
      default:      ;
    endcase
  endtask

  // random items: mostly target then ticks circling it, some pure noise
  task automatic random_run(int count);
    logic [31:0] gx, gy, gz, off;
    int          kind, k;
    k = 0;
    while (k < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        send_item(cvc_pkg::OP_GOAL, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, 1'b0, '0);
        k++;
      end else if (kind < 4) begin
        send_item(cvc_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, 1'b0, '0);
        k++;
      end else begin
        gx = $urandom; gy = $urandom; gz = $urandom;
        send_item(cvc_pkg::OP_GOAL, $urandom, $urandom, $urandom, gx, gy, gz,
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0400_0000),
                  1'b0, '0);
        k++;
        repeat ($urandom_range(2, 8)) begin
          // offsets from far away down to inside the deadband
          off = $urandom >> $urandom_range(0, 31);
          send_item(cvc_pkg::OP_TICK, gx + off, gy - (off >> 1), gz + $urandom_range(0, 3),
                    $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
          k++;
        end
      end
    end
  endtask

  // output stall: random, mostly short, a few long, none while calm
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 49) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(20, 120);
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    vel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_vel.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time, vel_x_o, vel_y_o, vel_z_o);
        errors++;
      end else begin
        want = pending_vel.pop_front();
        if (vel_x_o !== want.x) begin
          $display("%0t: vel_x expected %h actual %h", $time, want.x, vel_x_o);
          errors++;
        end
        if (vel_y_o !== want.y) begin
          $display("%0t: vel_y expected %h actual %h", $time, want.y, vel_y_o);
          errors++;
        end
        if (vel_z_o !== want.z) begin
          $display("%0t: vel_z expected %h actual %h", $time, want.z, vel_z_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

  row_t rows[$];

  task automatic add_row(logic op, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                         logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                         logic [31:0] sp, bit typed, vel_t v);
    row_t r;
    r.op = op; r.px = px; r.py = py; r.pz = pz;
    r.gx = gx; r.gy = gy; r.gz = gz; r.sp = sp;
    r.typed = typed; r.vel = v;
    rows.push_back(r);
  endtask

  initial begin
    int wait_cycles;
    band_q = 64'(cvc_pkg::DEADBAND_RST);
    decay_q = 64'(cvc_pkg::DECAY_RST);
    alpha_q = 64'(cvc_pkg::ALPHA_RST);
    aim_x = 0; aim_y = 0; aim_z = 0; aim_speed = 0; target_set = 1'b0;
    last_vx = 0; last_vy = 0; last_vz = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: first tick adopts its own position, so the velocity stays zero
    add_row(cvc_pkg::OP_TICK, 32'h7fff_ffff, 32'h8000_0000, 32'h0, '1, '1, '1, '1,
            1'b1, '0);
    add_row(cvc_pkg::OP_TICK, 32'h7fff_ffff, 32'h8000_0000, 32'h0, '0, '0, '0, '0,
            1'b1, '0);
    // no speed yet: far away still gives zero
    add_row(cvc_pkg::OP_TICK, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, '0, '0, '0, '0,
            1'b1, '0);
    // extreme target and speed, full-range differences
    add_row(cvc_pkg::OP_GOAL, '1, '1, '1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h7fff_ffff, 1'b0, '0);
    add_row(cvc_pkg::OP_TICK, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '0, '0, '0, '0,
            1'b0, '0);
    add_row(cvc_pkg::OP_TICK, 32'h0, 32'h0, 32'h0, '0, '0, '0, '0, 1'b0, '0);
    // negative speed pushes away from the target
    add_row(cvc_pkg::OP_GOAL, '0, '0, '0, 32'h0100_0000, 32'h0, 32'hff00_0000,
            32'h8000_0000, 1'b0, '0);
    add_row(cvc_pkg::OP_TICK, 32'h0, 32'h0100_0000, 32'h0, '0, '0, '0, '0, 1'b0, '0);
    add_row(cvc_pkg::OP_TICK, 32'hff00_0000, 32'h0, 32'h0100_0000, '0, '0, '0, '0,
            1'b0, '0);
    // zero distance and inside the deadband: decay
    add_row(cvc_pkg::OP_TICK, 32'h0100_0000, 32'h0, 32'hff00_0000, '0, '0, '0, '0,
            1'b0, '0);
    add_row(cvc_pkg::OP_TICK, 32'h0100_0100, 32'h0000_0100, 32'hff00_0001, '0, '0, '0, '0,
            1'b0, '0);
    // single-lsb distance, half of it rounds the norm to zero
    add_row(cvc_pkg::OP_TICK, 32'h0100_0001, 32'h0, 32'hff00_0000, '0, '0, '0, '0,
            1'b0, '0);
    // zero speed far away
    add_row(cvc_pkg::OP_GOAL, '0, '0, '0, 32'h1234_5678, 32'hedcb_a987, 32'h5555_aaaa,
            32'h0, 1'b0, '0);
    add_row(cvc_pkg::OP_TICK, 32'h0, 32'h0, 32'h0, '0, '0, '0, '0, 1'b0, '0);
    // unit speed just outside the deadband
    add_row(cvc_pkg::OP_GOAL, '0, '0, '0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
            32'h0100_0000, 1'b0, '0);
    add_row(cvc_pkg::OP_TICK, 32'h0005_3000, 32'h0, 32'h0, '0, '0, '0, '0, 1'b0, '0);

    calm = 1'b1;
    foreach (rows[i])
      send_item(rows[i].op, rows[i].px, rows[i].py, rows[i].pz, rows[i].gx, rows[i].gy,
                rows[i].gz, rows[i].sp, rows[i].typed, rows[i].vel);
    calm = 1'b0;
    random_run(200);
    drain();

    // lightest filter, zero decay factor, no deadband; out-of-range index must be ignored
    write_cfg(cvc_pkg::CFG_DEADBAND, 25'd0);
    write_cfg(cvc_pkg::CFG_DECAY, 25'd0);
    write_cfg(cvc_pkg::CFG_ALPHA, 25'h1ff_ffff);
    write_cfg(CFG_UNUSED, 25'h155_5555);
    random_run(200);
    drain();

    // widest deadband, decay factor near one, frozen filter then stepped
    write_cfg(cvc_pkg::CFG_DEADBAND, 25'h100_0000);
    write_cfg(cvc_pkg::CFG_DECAY, 25'd65535);
    write_cfg(cvc_pkg::CFG_ALPHA, 25'd0);
    random_run(100);
    drain();
    write_cfg(cvc_pkg::CFG_ALPHA, 25'd32768);
    calm = 1'b1;
    random_run(150);
    calm = 1'b0;
    drain();

    // random settings
    repeat (2) begin
      write_cfg(cvc_pkg::CFG_DEADBAND, 25'($urandom_range(0, 25'h100_0000)));
      write_cfg(cvc_pkg::CFG_DECAY, 25'($urandom));
      write_cfg(cvc_pkg::CFG_ALPHA, 25'($urandom));
      random_run(180);
      drain();
    end

    // back to defaults
    write_cfg(cvc_pkg::CFG_DEADBAND, cvc_pkg::DEADBAND_RST);
    write_cfg(cvc_pkg::CFG_DECAY, 25'(cvc_pkg::DECAY_RST));
    write_cfg(cvc_pkg::CFG_ALPHA, 25'(cvc_pkg::ALPHA_RST));
    random_run(30);
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (pending_vel.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_vel.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_vel.size());
      errors++;
    end
    $display("tb: %0d ticks, %0d targets, %0d results checked", n_ticks, n_targets,
             n_results);
    $display("tb: six register settings incl. extremes, random stalls on both sides");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
